>>> hw/rtl/pcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcr_pkg
// Shared types and helpers for the contour-to-corner-ring block: controller
// states, the command and status groups, and corner geometry.
// ----------------------------------------------------------------------------
package pcr_pkg;

  // corner numbering, clockwise from the top-left of a pixel
  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  // last step of the corner walk (fourth vertex)
  localparam logic [1:0] WALK_LAST_STEP = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_CLOSE
  } pcr_state_e;

  // controller to datapath
  typedef struct packed {
    logic take;        // capture the incoming pixel
    logic walk_emit;   // emit one walk vertex and advance the corner
    logic close_emit;  // emit the closing vertex of the ring
  } pcr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic have_prev;   // a previous pixel of the contour is held
    logic match;       // current walk vertex is a corner of the new pixel
    logic k_last;      // walk is on its fourth vertex
    logic cur_last;    // held pixel is the last of its contour
    logic out_free;    // output register can take a vertex this cycle
  } pcr_sts_t;

  // x offset of a corner from the pixel origin
  function automatic logic corner_dx(input logic [1:0] c);
    corner_dx = (c == CORNER_TR) || (c == CORNER_BR);
  endfunction

  // y offset of a corner from the pixel origin
  function automatic logic corner_dy(input logic [1:0] c);
    corner_dy = (c == CORNER_BR) || (c == CORNER_BL);
  endfunction

  // corner index from the offsets of a vertex within a pixel
  function automatic logic [1:0] corner_from_offset(input logic dx, input logic dy);
    logic [1:0] idx;
    if (!dy) begin
      idx = dx ? CORNER_TR : CORNER_TL;
    end else begin
      idx = dx ? CORNER_BR : CORNER_BL;
    end
    corner_from_offset = idx;
  endfunction

endpackage

>>> hw/rtl/pcr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcr_ctrl
// Controller for the corner ring: accepts one pixel, walks the previous pixel's
// corners, a vertex per free output slot, then emits the closing vertex if last.
// ----------------------------------------------------------------------------
module pcr_ctrl
  import pcr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pixel_valid_i,
  input  logic      last_pixel_i,
  output logic      pixel_stall_o,
  input  pcr_sts_t  sts_i,
  output pcr_cmd_t  cmd_o
);

  pcr_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pixel_valid_i) begin
          if (sts_i.have_prev) begin
            state_d = ST_WALK;
          end else if (last_pixel_i) begin
            state_d = ST_CLOSE;
          end
        end
      end
      ST_WALK: begin
        if (sts_i.out_free && (sts_i.match || sts_i.k_last)) begin
          state_d = sts_i.cur_last ? ST_CLOSE : ST_IDLE;
        end
      end
      ST_CLOSE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o         = '0;
    pixel_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        pixel_stall_o = 1'b0;
        cmd_o.take    = pixel_valid_i;
      end
      ST_WALK: begin
        cmd_o.walk_emit = sts_i.out_free;
      end
      ST_CLOSE: begin
        cmd_o.close_emit = sts_i.out_free;
      end
      default: begin
        pixel_stall_o = 1'b1;
      end
    endcase
  end

endmodule

>>> hw/rtl/pcr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcr_datapath
// Pixel registers, corner walk index, corner match logic and the output
// register of the corner ring.
// ----------------------------------------------------------------------------
module pcr_datapath
  import pcr_pkg::*;
#(
  parameter int COORD_BITS = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [COORD_BITS-1:0] pixel_x_i,
  input  logic [COORD_BITS-1:0] pixel_y_i,
  input  logic                  last_pixel_i,
  input  pcr_cmd_t              cmd_i,
  output pcr_sts_t              sts_o,
  output logic                  vertex_valid_o,
  input  logic                  vertex_stall_i,
  output logic [COORD_BITS:0]   vertex_x_o,
  output logic [COORD_BITS:0]   vertex_y_o,
  output logic                  ring_end_o,
  output logic                  not_adjacent_o
);

  localparam int VW = COORD_BITS + 1;
  localparam int DW = COORD_BITS + 2;

  logic                  have_prev_q;
  logic [COORD_BITS-1:0] prev_x_q, prev_y_q;
  logic [COORD_BITS-1:0] cur_x_q, cur_y_q;
  logic                  cur_last_q;
  logic [1:0]            corner_q;
  logic [1:0]            k_q;

  logic                  out_valid_q;
  logic [VW-1:0]         out_x_q, out_y_q;
  logic                  out_end_q, out_err_q;

  logic [VW-1:0]         walk_x, walk_y;
  logic [DW-1:0]         diff_x, diff_y;
  logic                  hit_x, hit_y, match;
  logic [1:0]            shared_idx;
  logic                  k_last, out_free;

  // current walk vertex on the previous pixel
  assign walk_x = {1'b0, prev_x_q} + VW'(corner_dx(corner_q));
  assign walk_y = {1'b0, prev_y_q} + VW'(corner_dy(corner_q));

  // offset of the walk vertex from the new pixel: must be 0 or 1 in both axes
  assign diff_x = {1'b0, walk_x} - {2'b00, cur_x_q};
  assign diff_y = {1'b0, walk_y} - {2'b00, cur_y_q};
  assign hit_x  = (diff_x[DW-1:1] == '0);
  assign hit_y  = (diff_y[DW-1:1] == '0);
  assign match  = hit_x && hit_y;
  assign shared_idx = corner_from_offset(diff_x[0], diff_y[0]);

  assign k_last   = (k_q == WALK_LAST_STEP);
  assign out_free = !out_valid_q || !vertex_stall_i;

  // status to the controller
  always_comb begin
    sts_o.have_prev = have_prev_q;
    sts_o.match     = match;
    sts_o.k_last    = k_last;
    sts_o.cur_last  = cur_last_q;
    sts_o.out_free  = out_free;
  end

  // contour state and walk index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      corner_q    <= CORNER_TL;
      k_q         <= '0;
    end else begin
      if (cmd_i.take) begin
        k_q <= '0;
        if (!have_prev_q) begin
          have_prev_q <= 1'b1;
          corner_q    <= CORNER_TL;
        end
      end else if (cmd_i.walk_emit) begin
        if (match) begin
          corner_q <= shared_idx + 2'd1;
        end else if (k_last) begin
          corner_q <= CORNER_TL;
        end else begin
          corner_q <= corner_q + 2'd1;
          k_q      <= k_q + 2'd1;
        end
      end else if (cmd_i.close_emit) begin
        have_prev_q <= 1'b0;
        corner_q    <= CORNER_TL;
      end
    end
  end

  // pixel coordinate registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      cur_x_q    <= pixel_x_i;
      cur_y_q    <= pixel_y_i;
      cur_last_q <= last_pixel_i;
      if (!have_prev_q) begin
        prev_x_q <= pixel_x_i;
        prev_y_q <= pixel_y_i;
      end
    end else if (cmd_i.walk_emit && (match || k_last)) begin
      prev_x_q <= cur_x_q;
      prev_y_q <= cur_y_q;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.walk_emit || cmd_i.close_emit) begin
      out_valid_q <= 1'b1;
    end else if (!vertex_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_emit) begin
      out_x_q   <= walk_x;
      out_y_q   <= walk_y;
      out_end_q <= 1'b0;
      out_err_q <= !match && k_last;
    end else if (cmd_i.close_emit) begin
      out_x_q   <= {1'b0, cur_x_q};
      out_y_q   <= {1'b0, cur_y_q};
      out_end_q <= 1'b1;
      out_err_q <= 1'b0;
    end
  end

  assign vertex_valid_o = out_valid_q;
  assign vertex_x_o     = out_x_q;
  assign vertex_y_o     = out_y_q;
  assign ring_end_o     = out_end_q;
  assign not_adjacent_o = out_err_q;

endmodule

>>> hw/rtl/pixel_contour_to_corner_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_contour_to_corner_ring
// Converts a stream of traced contour pixels into the ring of pixel-corner
// vertices that runs along the contour's pixel boundaries.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel channel: pixel_valid_i / pixel_stall_o with pixel_x_i, pixel_y_i and
//   last_pixel_i. Vertex channel: vertex_valid_o / vertex_stall_i with
//   vertex_x_o, vertex_y_o, ring_end_o and not_adjacent_o. A transaction
//   completes on a rising edge with valid high and stall low.
//   One pixel is processed at a time. The first pixel of a contour is taken
//   and yields nothing (or only its closing vertex if marked last). A later
//   pixel is taken, then its walk emits one to four vertices, and after the
//   last pixel the closing vertex follows. The single vertex output register
//   takes one vertex per cycle while the receiver does not stall. The first
//   vertex of a pixel passes the state register and then the output register
//   before its transaction can complete. not_adjacent_o marks the fourth walk
//   vertex when no corner is shared; ring_end_o marks the closing vertex.
//   While the receiver stalls, the held vertex stays on the port and the walk
//   waits; the pixel channel stalls until the current pixel is finished.
//   Reset clears the controller, the contour state and the output valid; the
//   next pixel after reset starts a new contour.
// ----------------------------------------------------------------------------
module pixel_contour_to_corner_ring
  import pcr_pkg::*;
#(
  parameter int COORD_BITS = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pixel_valid_i,
  output logic                  pixel_stall_o,
  input  logic [COORD_BITS-1:0] pixel_x_i,
  input  logic [COORD_BITS-1:0] pixel_y_i,
  input  logic                  last_pixel_i,
  output logic                  vertex_valid_o,
  input  logic                  vertex_stall_i,
  output logic [COORD_BITS:0]   vertex_x_o,
  output logic [COORD_BITS:0]   vertex_y_o,
  output logic                  ring_end_o,
  output logic                  not_adjacent_o
);

  pcr_cmd_t cmd;
  pcr_sts_t sts;

  // controller
  pcr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pixel_valid_i (pixel_valid_i),
    .last_pixel_i  (last_pixel_i),
    .pixel_stall_o (pixel_stall_o),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // datapath
  pcr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .last_pixel_i   (last_pixel_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .vertex_valid_o (vertex_valid_o),
    .vertex_stall_i (vertex_stall_i),
    .vertex_x_o     (vertex_x_o),
    .vertex_y_o     (vertex_y_o),
    .ring_end_o     (ring_end_o),
    .not_adjacent_o (not_adjacent_o)
  );

  // the closing vertex never carries the error flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vertex_valid_o |-> !(ring_end_o && not_adjacent_o))
    else $error("closing vertex flagged not_adjacent");

  // a walk only runs against a held previous pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.walk_emit |-> sts.have_prev)
    else $error("corner walk without previous pixel");

  // error flag only on the fourth unmatched walk vertex
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.walk_emit && !sts.match && !sts.k_last) |=> !not_adjacent_o)
    else $error("not_adjacent raised before fourth step");

  // closing the ring ends the contour
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.close_emit |=> !sts.have_prev)
    else $error("contour still open after closing vertex");

endmodule
